[design/bis_pkg.sv]
`timescale 1ns / 1ps

package bis_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned VALUE_W   = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_set;
    logic                      overflow;
  } out_req_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_e;

endpackage

[design/bis_cell.sv]
`timescale 1ns / 1ps

module bis_cell
  import bis_pkg::*;
(
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic                      occupied_i,
  input  logic signed [VALUE_W-1:0] new_value_i,
  input  logic                      left_gt_i,
  input  logic signed [VALUE_W-1:0] left_value_i,
  input  logic signed [VALUE_W-1:0] right_value_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      gt_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;

  // An empty slot counts as greater so the new value lands in the first free one
  assign gt_o    = !occupied_i || (value_q > new_value_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert) begin
      if (left_gt_i) begin
        value_d = left_value_i;
      end else if (gt_o) begin
        value_d = new_value_i;
      end
    end else if (ctrl_i.shift) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

[design/binary_insertion_sorter.sv]
// Latency: the first result is valid the cycle after the request marked last is taken.
// Throughput: one input request per cycle while filling; a set then drains one
// entry per taken output, during which input is stalled.
// Reset: asynchronous, active low; empties the chain and clears the overflow flag.
// The chain's value registers are not reset; only the fill count marks live cells.
`timescale 1ns / 1ps

module binary_insertion_sorter
  import bis_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  state_e                    state_q, state_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic                      ovf_q, ovf_d;
  cell_ctrl_t                ctrl;
  logic                      in_acc;
  logic                      out_acc;
  logic                      full;

  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic                      cell_gt    [DEPTH];

  // Accept new values only while filling; the chain drains from cell 0
  assign in_stall_o  = (state_q != ST_FILL);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign full        = (fill_q == FILL_W'(DEPTH));

  assign out_req_o.sorted_value = cell_value[0];
  assign out_req_o.end_of_set   = (fill_q == FILL_W'(1));
  assign out_req_o.overflow     = ovf_q;

  // Row of compare-and-shift cells. On insert every cell past the first one
  // larger than the new value takes its left neighbour, and that first cell
  // takes the new value. On shift every cell takes its right neighbour.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      left_gt;
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_value = in_req_i.value;
    end else begin : g_body
      assign left_gt    = cell_gt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    bis_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (FILL_W'(i) < fill_q),
      .new_value_i   (in_req_i.value),
      .left_gt_i     (left_gt),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .gt_o          (cell_gt[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          // Drop the value when the chain is full, and remember it
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            fill_d      = fill_q + FILL_W'(1);
          end
          if (in_req_i.is_last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          // Advance the chain towards cell 0 as each result leaves
          ctrl.shift = 1'b1;
          fill_d     = fill_q - FILL_W'(1);
          if (fill_q == FILL_W'(1)) begin
            state_d = ST_FILL;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(DEPTH))
    else $error("fill count beyond chain depth");

  a_emit_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_q != '0))
    else $error("result offered from an empty chain");

  a_drop_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full && !in_req_i.is_last) |=> ovf_q)
    else $error("dropped value did not raise overflow");

  a_insert_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !full) |=> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("insert did not grow the fill count");

  a_set_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_req_o.end_of_set) |=> (!out_valid_o && fill_q == '0 && !ovf_q))
    else $error("set did not close after its final result");

  a_drain_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_req_o.end_of_set) |=> out_valid_o)
    else $error("drain stopped before the final result");
`endif

endmodule
